FILE: src/scpa_pkg.sv
// Shared types, constants and fixed-point helpers for the sphere contact push accumulator.
// Used by scpa_alu and by the top level; depends on nothing else.
package scpa_pkg;

    // Datapath width of the shared arithmetic unit
    localparam int ALU_W = 64;

    // Configuration register indexes
    localparam logic [7:0] CFG_CENTER_X = 8'd0;
    localparam logic [7:0] CFG_CENTER_Y = 8'd1;
    localparam logic [7:0] CFG_CENTER_Z = 8'd2;
    localparam logic [7:0] CFG_RADIUS   = 8'd3;

    localparam logic [30:0] RADIUS_RESET = 31'd32768;

    // Stream payload widths
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 96;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic                     start;
        t_alu_op                  op;
        logic signed [ALU_W-1:0]  a;
        logic signed [ALU_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic signed [ALU_W-1:0]  res;
    } t_alu_rsp;

    // Divide by 2^16, truncating toward zero
    function automatic logic signed [63:0] trunc16(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v[63] ? (v + 64'sd65535) : v;
        return t >>> 16;
    endfunction

    // Saturate to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/scpa_alu.sv
// Shared bit-serial arithmetic unit: signed multiply, signed truncating divide, integer sqrt.
// One bit of work per cycle; depends on scpa_pkg.
module scpa_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scpa_pkg::t_alu_req  i_req,
    output scpa_pkg::t_alu_rsp  o_rsp
);
    import scpa_pkg::*;

    logic                r_busy;
    t_alu_op             r_op;
    logic [ALU_W-1:0]    r_x;
    logic [ALU_W-1:0]    r_y;
    logic [ALU_W-1:0]    r_acc;
    logic [5:0]          r_cnt;
    logic                r_neg;
    logic                r_done;
    logic signed [ALU_W-1:0] r_res;

    logic [ALU_W-1:0] w_abs_a;
    logic [ALU_W-1:0] w_abs_b;
    logic [ALU_W-1:0] w_rem;
    logic             w_ge;
    logic [ALU_W-1:0] w_qn;
    logic [ALU_W-1:0] w_trial;

    // Operand magnitudes and the per-step terms
    always_comb begin
        w_abs_a = i_req.a[ALU_W-1] ? ALU_W'(-i_req.a) : ALU_W'(i_req.a);
        w_abs_b = i_req.b[ALU_W-1] ? ALU_W'(-i_req.b) : ALU_W'(i_req.b);
        w_rem   = {r_acc[ALU_W-2:0], r_x[ALU_W-1]};
        w_ge    = (w_rem >= r_y);
        w_qn    = {r_x[ALU_W-2:0], w_ge};
        w_trial = r_acc + r_y;
    end

    // Sequence one operation, one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_op   <= i_req.op;
                    r_cnt  <= 6'd63;
                    r_acc  <= '0;
                    r_neg  <= i_req.a[ALU_W-1] ^ i_req.b[ALU_W-1];
                    case (i_req.op)
                        ALU_MUL: begin
                            r_x <= w_abs_a;
                            r_y <= w_abs_b;
                        end
                        ALU_DIV: begin
                            r_x <= w_abs_a;
                            r_y <= w_abs_b;
                        end
                        ALU_SQRT: begin
                            r_x <= ALU_W'(i_req.a);
                            r_y <= ALU_W'(64'h4000_0000_0000_0000);
                        end
                        default: begin
                            r_busy <= 1'b0;
                        end
                    endcase
                end
            end else begin
                case (r_op)
                    ALU_MUL: begin
                        if (r_y == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= r_neg ? -$signed(r_acc) : $signed(r_acc);
                        end else begin
                            if (r_y[0]) begin
                                r_acc <= r_acc + r_x;
                            end
                            r_x <= {r_x[ALU_W-2:0], 1'b0};
                            r_y <= {1'b0, r_y[ALU_W-1:1]};
                        end
                    end
                    ALU_DIV: begin
                        r_acc <= w_ge ? (w_rem - r_y) : w_rem;
                        r_x   <= w_qn;
                        r_cnt <= r_cnt - 6'd1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= r_neg ? -$signed(w_qn) : $signed(w_qn);
                        end
                    end
                    ALU_SQRT: begin
                        if (r_y == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= $signed(r_acc);
                        end else begin
                            if (r_x >= w_trial) begin
                                r_x   <= r_x - w_trial;
                                r_acc <= {1'b0, r_acc[ALU_W-1:1]} + r_y;
                            end else begin
                                r_acc <= {1'b0, r_acc[ALU_W-1:1]};
                            end
                            r_y <= {2'b00, r_y[ALU_W-1:2]};
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

FILE: src/sphere_contact_push_accumulator.sv
// Top level of the sphere contact push accumulator: stream ports, configuration,
// sequencer and accumulator state; depends on scpa_pkg and scpa_alu.
//
// Each contact beat is worked through one shared bit-serial unit (multiply, divide,
// square root, one bit per cycle), so the input is not ready while a contact is in
// work. A contact at the sphere centre stops after its first square root; any other
// takes up to 19 multiplies, 4 divides and 2 square roots (a multiply stops at the
// top set bit of its second operand). A beat with contact_valid low does no
// arithmetic. The result of a beat marked last waits in an output register; a
// further last beat stalls only until that register has been taken. Configuration
// writes are always ready and must only be issued while the block is idle.
module sphere_contact_push_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: hit_x[31:0], hit_y[63:32], hit_z[95:64], normal_x[113:96],
    //        normal_y[131:114], normal_z[149:132], zero pad [151:150]
    input  logic [scpa_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: contact_valid
    input  logic                              i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: push_x[31:0], push_y[63:32], push_z[95:64]
    output logic [scpa_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: hit[0], degenerate[1]
    output logic [1:0]                        o_m_axis_tuser,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [7:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import scpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        ST_SQ_M,
        ST_LEN,
        ST_DOT_N,
        ST_Q,
        ST_P,
        ST_PUSH,
        ST_SQ_A,
        ST_ALEN,
        ST_U,
        ST_DOT_U,
        ST_CORR
    } t_step;

    t_state r_state;
    t_step  r_step;
    logic [1:0] r_idx;

    // Configuration
    logic signed [31:0] r_center [3];
    logic [30:0]        r_radius;

    // Per-contact working values
    logic signed [31:0] r_m   [3];
    logic signed [17:0] r_n   [3];
    logic signed [31:0] r_pv  [3];
    logic signed [17:0] r_u   [3];
    logic signed [63:0] r_sum;
    logic [31:0]        r_len;
    logic [31:0]        r_alen;
    logic signed [63:0] r_q;
    logic signed [63:0] r_p;
    logic signed [63:0] r_dot;
    logic               r_last;
    logic               r_valid_item;

    // Accumulator
    logic signed [31:0] r_acc [3];
    logic               r_degen;

    // Output register
    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic [1:0]             r_ouser;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    logic signed [63:0] w_nsum;
    logic signed [63:0] w_dot;
    logic signed [63:0] w_corr;
    logic signed [31:0] w_hit [3];
    logic               w_in_acc;
    logic               w_idx_end;

    scpa_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_idx_end = (r_idx == 2'd2);

    assign w_hit[0] = i_s_axis_tdata[31:0];
    assign w_hit[1] = i_s_axis_tdata[63:32];
    assign w_hit[2] = i_s_axis_tdata[95:64];

    // Running sum, dot term and correction from the unit's result
    always_comb begin
        w_nsum = ((r_idx == 2'd0) ? 64'sd0 : r_sum) + w_rsp.res;
        w_dot  = trunc16(w_nsum);
        w_corr = 64'(r_acc[r_idx]) + 64'(r_pv[r_idx]) - trunc16(w_rsp.res);
    end

    // Select operands for the current step
    always_comb begin
        w_req.start = (r_state == S_ISSUE);
        w_req.op    = ALU_MUL;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_step)
            ST_SQ_M: begin
                w_req.a = 64'(r_m[r_idx]);
                w_req.b = 64'(r_m[r_idx]);
            end
            ST_LEN: begin
                w_req.op = ALU_SQRT;
                w_req.a  = r_sum;
            end
            ST_DOT_N: begin
                w_req.a = 64'(r_m[r_idx]);
                w_req.b = 64'(r_n[r_idx]);
            end
            ST_Q: begin
                w_req.op = ALU_DIV;
                w_req.a  = trunc16(r_sum) <<< 16;
                w_req.b  = $signed({32'd0, r_len});
            end
            ST_P: begin
                w_req.a = r_q;
                w_req.b = $signed({33'd0, r_radius}) - $signed({32'd0, r_len});
            end
            ST_PUSH: begin
                w_req.a = 64'(r_n[r_idx]);
                w_req.b = r_p;
            end
            ST_SQ_A: begin
                w_req.a = 64'(r_acc[r_idx]);
                w_req.b = 64'(r_acc[r_idx]);
            end
            ST_ALEN: begin
                w_req.op = ALU_SQRT;
                w_req.a  = r_sum;
            end
            ST_U: begin
                w_req.op = ALU_DIV;
                w_req.a  = 64'(r_acc[r_idx]) <<< 16;
                w_req.b  = $signed({32'd0, r_alen});
            end
            ST_DOT_U: begin
                w_req.a = 64'(r_pv[r_idx]);
                w_req.b = 64'(r_u[r_idx]);
            end
            ST_CORR: begin
                w_req.a = 64'(r_u[r_idx]);
                w_req.b = r_dot;
            end
            default: begin
                w_req.op = ALU_MUL;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                CFG_RADIUS:   r_radius    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Sequencer, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= ST_SQ_M;
            r_idx        <= '0;
            r_acc[0]     <= '0;
            r_acc[1]     <= '0;
            r_acc[2]     <= '0;
            r_degen      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_last       <= 1'b0;
            r_valid_item <= 1'b0;
        end else begin
            // Drop the result once taken
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_last       <= i_s_axis_tlast;
                        r_valid_item <= i_s_axis_tuser;
                        if (i_s_axis_tuser) begin
                            for (int i = 0; i < 3; i++) begin
                                r_m[i] <= sat32(64'(r_center[i]) - 64'(w_hit[i]));
                            end
                            r_n[0] <= i_s_axis_tdata[113:96];
                            r_n[1] <= i_s_axis_tdata[131:114];
                            r_n[2] <= i_s_axis_tdata[149:132];
                            r_step  <= ST_SQ_M;
                            r_idx   <= '0;
                            r_state <= S_ISSUE;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= S_ISSUE;
                        case (r_step)
                            ST_SQ_M: begin
                                r_sum <= w_nsum;
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_step <= ST_LEN;
                                end
                            end
                            ST_LEN: begin
                                r_len <= w_rsp.res[31:0];
                                r_idx <= '0;
                                r_step <= ST_DOT_N;
                                if (w_rsp.res == '0) begin
                                    r_degen <= 1'b1;
                                    r_state <= r_last ? S_EMIT : S_IDLE;
                                end
                            end
                            ST_DOT_N: begin
                                r_sum <= w_nsum;
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_step <= ST_Q;
                                end
                            end
                            ST_Q: begin
                                r_q    <= w_rsp.res;
                                r_step <= ST_P;
                            end
                            ST_P: begin
                                r_p    <= trunc16(w_rsp.res);
                                r_idx  <= '0;
                                r_step <= ST_PUSH;
                            end
                            ST_PUSH: begin
                                r_pv[r_idx] <= sat32(trunc16(w_rsp.res));
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_idx  <= '0;
                                    r_step <= ST_SQ_A;
                                end
                            end
                            ST_SQ_A: begin
                                r_sum <= w_nsum;
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_step <= ST_ALEN;
                                end
                            end
                            ST_ALEN: begin
                                r_alen <= w_rsp.res[31:0];
                                r_idx  <= '0;
                                r_step <= ST_U;
                                if (w_rsp.res == '0) begin
                                    // Empty accumulator: take the new push as it is
                                    r_acc   <= r_pv;
                                    r_state <= r_last ? S_EMIT : S_IDLE;
                                end
                            end
                            ST_U: begin
                                r_u[r_idx] <= w_rsp.res[17:0];
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_idx  <= '0;
                                    r_step <= ST_DOT_U;
                                end
                            end
                            ST_DOT_U: begin
                                r_sum <= w_nsum;
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_dot  <= w_dot;
                                    r_idx  <= '0;
                                    r_step <= ST_CORR;
                                    if (!(w_dot < $signed({32'd0, r_alen}))) begin
                                        // Push reaches past the current one: replace
                                        r_acc   <= r_pv;
                                        r_state <= r_last ? S_EMIT : S_IDLE;
                                    end
                                end
                            end
                            ST_CORR: begin
                                r_acc[r_idx] <= sat32(w_corr);
                                r_idx <= r_idx + 2'd1;
                                if (w_idx_end) begin
                                    r_state <= r_last ? S_EMIT : S_IDLE;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    // Load the result beat once the output register is free
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ouser  <= {r_valid_item & r_degen, r_valid_item};
                        r_odata  <= r_valid_item ? {r_acc[2], r_acc[1], r_acc[0]} : '0;
                        r_acc[0] <= '0;
                        r_acc[1] <= '0;
                        r_acc[2] <= '0;
                        r_degen  <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/tb_sphere_contact_push_accumulator.sv
// Self-checking testbench for sphere_contact_push_accumulator: a queue-fed stream driver, an
// output monitor and a bit-accurate push predictor. Depends on scpa_pkg and the block itself.
module tb_sphere_contact_push_accumulator;
    import scpa_pkg::*;

    localparam int  SETTLE_CYCLES = 2000;
    localparam int  CYCLE_LIMIT   = 6000000;
    localparam int  PHASE_ITEMS   = 140;

    typedef struct {
        bit                 cv;
        logic signed [31:0] hx, hy, hz;
        logic signed [17:0] nx, ny, nz;
        bit                 last;
    } contact_t;

    typedef struct {
        bit                 hit;
        logic signed [31:0] px, py, pz;
        bit                 degen;
    } push_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   i_s_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [1:0]             o_m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [7:0]             i_cfg_index;
    logic [31:0]            i_cfg_data;

    sphere_contact_push_accumulator dut (.*);

    // Predictor state: sphere settings and running push
    longint  ctr_x, ctr_y, ctr_z, rad;
    longint  acc_x, acc_y, acc_z;
    bit      degen_seen;

    contact_t contact_q[$];
    push_t    push_q[$];
    contact_t cur_beat;
    int       gap_left;
    int       stall_left;
    int       n_errors;
    int       n_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint mag3(longint x, longint y, longint z);
        longint unsigned s;
        s = longint'(x * x) + longint'(y * y) + longint'(z * z);
        return longint'(root64(s));
    endfunction

    // Fold one contact into the running push
    task automatic fold_contact(contact_t c);
        longint mx, my, mz, nx, ny, nz, len, d, q, p, px, py, pz;
        longint alen, ux, uy, uz, dt;
        mx = clamp32(ctr_x - longint'(c.hx));
        my = clamp32(ctr_y - longint'(c.hy));
        mz = clamp32(ctr_z - longint'(c.hz));
        nx = longint'(c.nx);
        ny = longint'(c.ny);
        nz = longint'(c.nz);
        len = mag3(mx, my, mz);
        if (len == 0) begin
            degen_seen = 1'b1;
            return;
        end
        d  = (mx * nx + my * ny + mz * nz) / 65536;
        q  = d * 65536 / len;
        p  = q * (rad - len) / 65536;
        px = clamp32(nx * p / 65536);
        py = clamp32(ny * p / 65536);
        pz = clamp32(nz * p / 65536);
        alen = mag3(acc_x, acc_y, acc_z);
        ux = 0; uy = 0; uz = 0;
        if (alen != 0) begin
            ux = acc_x * 65536 / alen;
            uy = acc_y * 65536 / alen;
            uz = acc_z * 65536 / alen;
        end
        dt = (px * ux + py * uy + pz * uz) / 65536;
        if (dt < alen) begin
            acc_x = clamp32(acc_x + px - ux * dt / 65536);
            acc_y = clamp32(acc_y + py - uy * dt / 65536);
            acc_z = clamp32(acc_z + pz - uz * dt / 65536);
        end else begin
            acc_x = px;
            acc_y = py;
            acc_z = pz;
        end
    endtask

    // Advance the predictor by one accepted beat; queue the push on a last beat
    task automatic predict_push(contact_t c);
        push_t e;
        if (c.cv) fold_contact(c);
        if (c.last) begin
            e.hit   = c.cv;
            e.px    = c.cv ? acc_x[31:0] : '0;
            e.py    = c.cv ? acc_y[31:0] : '0;
            e.pz    = c.cv ? acc_z[31:0] : '0;
            e.degen = c.cv && degen_seen;
            push_q.push_back(e);
            acc_x = 0; acc_y = 0; acc_z = 0;
            degen_seen = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, n_cycles);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Driver: take the current beat when accepted, then hold off or load the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_push(cur_beat);
                gap_left = pick_gap();
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (contact_q.size() > 0) begin
                    cur_beat = contact_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {2'b00, cur_beat.nz, cur_beat.ny, cur_beat.nx,
                                        cur_beat.hz, cur_beat.hy, cur_beat.hx};
                    i_s_axis_tuser  <= cur_beat.cv;
                    i_s_axis_tlast  <= cur_beat.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest expected push, stall at random
    always @(posedge i_clk) begin
        push_t e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (push_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = push_q.pop_front();
                    if (o_m_axis_tuser[0] !== e.hit)
                        report_mismatch("hit", o_m_axis_tuser[0], e.hit);
                    if (o_m_axis_tuser[1] !== e.degen)
                        report_mismatch("degenerate", o_m_axis_tuser[1], e.degen);
                    if (o_m_axis_tdata[31:0] !== e.px)
                        report_mismatch("push_x", $signed(o_m_axis_tdata[31:0]), e.px);
                    if (o_m_axis_tdata[63:32] !== e.py)
                        report_mismatch("push_y", $signed(o_m_axis_tdata[63:32]), e.py);
                    if (o_m_axis_tdata[95:64] !== e.pz)
                        report_mismatch("push_z", $signed(o_m_axis_tdata[95:64]), e.pz);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                i_m_axis_tready <= (stall_left == 0);
            end
        end
    end

    function automatic logic signed [17:0] rand_normal();
        return 18'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic add_beat(bit cv, longint hx, longint hy, longint hz,
                            longint nx, longint ny, longint nz, bit last);
        contact_t c;
        c.cv = cv; c.last = last;
        c.hx = hx[31:0]; c.hy = hy[31:0]; c.hz = hz[31:0];
        c.nx = nx[17:0]; c.ny = ny[17:0]; c.nz = nz[17:0];
        contact_q.push_back(c);
    endtask

    // One contact near the sphere, normal pointing outward from the centre
    task automatic add_near(longint span, bit last);
        longint ox, oy, oz, l;
        ox = longint'($signed($urandom)) % (span + 1);
        oy = longint'($signed($urandom)) % (span + 1);
        oz = longint'($signed($urandom)) % (span + 1);
        l  = mag3(ox, oy, oz);
        if (l == 0) l = 1;
        add_beat(1'b1, clamp32(ctr_x + ox), clamp32(ctr_y + oy), clamp32(ctr_z + oz),
                 ox * 65536 / l, oy * 65536 / l, oz * 65536 / l, last);
    endtask

    // Random query: mostly well-formed contact lists, some noise; returns its beats counted, extra noise beats apart
    task automatic add_query(output int n);
        int k, r;
        longint span;
        span = (rad < 64) ? 64 : rad * 2;
        r = $urandom_range(0, 99);
        n = 0;
        if (r < 8) begin
            add_beat(1'b0, $signed($urandom), $signed($urandom), $signed($urandom),
                     rand_normal(), rand_normal(), rand_normal(), 1'b1);
            n = 1;
        end else begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    add_near(span, i == k - 1);
                end else if (r < 76) begin
                    add_beat(1'b1, ctr_x, ctr_y, ctr_z,
                             rand_normal(), rand_normal(), rand_normal(), i == k - 1);
                end else begin
                    add_beat(1'b1, $signed($urandom), $signed($urandom), $signed($urandom),
                             rand_normal(), rand_normal(), rand_normal(), i == k - 1);
                end
                if ($urandom_range(0, 9) == 0)
                    add_beat(1'b0, $signed($urandom), 0, 0, 0, 0, 0, 1'b0);
                n++;
            end
        end
    endtask

    // Wait until the sender has drained and every push has come back, then settle
    task automatic drain();
        while (contact_q.size() != 0 || i_s_axis_tvalid || push_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTER_X: ctr_x = longint'($signed(val));
            CFG_CENTER_Y: ctr_y = longint'($signed(val));
            CFG_CENTER_Z: ctr_z = longint'($signed(val));
            CFG_RADIUS:   rad   = longint'({1'b0, val[30:0]});
            default: ;
        endcase
    endtask

    task automatic set_sphere(longint cx, longint cy, longint cz, longint r);
        cfg_write(CFG_CENTER_X, cx[31:0]);
        cfg_write(CFG_CENTER_Y, cy[31:0]);
        cfg_write(CFG_CENTER_Z, cz[31:0]);
        cfg_write(CFG_RADIUS, r[31:0]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        int n, total;
        total = 0;
        while (total < PHASE_ITEMS) begin
            add_query(n);
            total += n;
            // hold the sender back until the block has caught up
            while (contact_q.size() > 8) @(posedge i_clk);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        n_errors = 0;
        n_cycles = 0;
        ctr_x = 0; ctr_y = 0; ctr_z = 0; rad = 32768;
        acc_x = 0; acc_y = 0; acc_z = 0; degen_seen = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats on the reset sphere
        add_beat(1'b1, 16384, 0, 0, -65536, 0, 0, 1'b1);
        add_beat(1'b1, 0, 0, 0, 65536, 0, 0, 1'b1);
        add_beat(1'b1, 0, 0, 0, 0, 0, 0, 1'b0);
        add_beat(1'b1, 0, -8192, 0, 0, 65536, 0, 1'b1);
        add_beat(1'b0, 0, 0, 0, 0, 0, 0, 1'b1);
        add_beat(1'b0, -1, -1, -1, -65536, -65536, -65536, 1'b0);
        add_beat(1'b1, 0, 0, 20000, 0, 0, -65536, 1'b0);
        add_beat(1'b1, 0, 20000, 0, 0, -65536, 0, 1'b0);
        add_beat(1'b1, 0, 0, 30000, 0, 0, -65536, 1'b1);
        add_beat(1'b1, 100000, 0, 0, -65536, 0, 0, 1'b1);
        add_beat(1'b1, 64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF,
                 65536, 65536, 65536, 1'b1);
        add_beat(1'b1, -64'sh80000000, -64'sh80000000, -64'sh80000000,
                 -65536, -65536, -65536, 1'b1);
        add_beat(1'b1, 10000, 10000, 0, -46341, -46341, 0, 1'b0);
        add_beat(1'b1, 0, 0, 0, 0, 0, 65536, 1'b0);
        add_beat(1'b0, 0, 0, 0, 0, 0, 0, 1'b1);
        add_beat(1'b1, 12000, 0, 0, -65536, 0, 0, 1'b0);
        add_beat(1'b1, -12000, 0, 0, 65536, 0, 0, 1'b0);
        add_beat(1'b1, 0, 0, 0, 1, -1, 0, 1'b1);
        drain();

        set_sphere(0, 0, 0, 65536);
        random_phase();
        set_sphere($signed($urandom_range(0, 1 << 24)) - (1 << 23),
                   $signed($urandom_range(0, 1 << 24)) - (1 << 23), 1 << 20, 4 * 65536);
        random_phase();
        set_sphere(64'sh7FFFFFFF, -64'sh80000000, 0, 64'sh7FFFFFFF);
        random_phase();
        set_sphere(-64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000, 0);
        random_phase();
        set_sphere($signed($urandom), $signed($urandom), $signed($urandom), 256);
        random_phase();

        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
